>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBES_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RBES_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBES_ASSERT(lbl, clk, rstn, prop, msg)
`define RBES_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/rbes_pkg.sv
package rbes_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 24;
  localparam int unsigned DivW  = WordW + FracW;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [DivW-1:0] dmag_t;

  // clamp a magnitude with sign into the signed word range
  function automatic word_t sat_mag(input dmag_t m, input logic neg);
    word_t r;
    if (neg) begin
      if (m >= dmag_t'({1'b1, {(WordW-1){1'b0}}})) r = {1'b1, {(WordW-1){1'b0}}};
      else r = -word_t'(m[WordW-1:0]);
    end else begin
      if (m > dmag_t'({1'b0, {(WordW-1){1'b1}}})) r = {1'b0, {(WordW-1){1'b1}}};
      else r = word_t'(m[WordW-1:0]);
    end
    return r;
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    word_t r;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) r = s[WordW] ? {1'b1, {(WordW-1){1'b0}}}
                                              : {1'b0, {(WordW-1){1'b1}}};
    else r = s[WordW-1:0];
    return r;
  endfunction
endpackage

>>> rtl/rbes_mul.sv
module rbes_mul (
  input  logic           clk_i,
  input  rbes_pkg::word_t a_i,
  input  rbes_pkg::word_t b_i,
  output rbes_pkg::word_t res_o
);
  logic [2*rbes_pkg::WordW-1:0] prod_q, prod_d;
  logic neg_q, neg_d;
  logic [rbes_pkg::WordW-1:0] ma, mb;

  always_comb begin
    ma = a_i[rbes_pkg::WordW-1] ? -a_i : a_i;
    mb = b_i[rbes_pkg::WordW-1] ? -b_i : b_i;
    prod_d = ma * mb;
    neg_d = a_i[rbes_pkg::WordW-1] ^ b_i[rbes_pkg::WordW-1];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q <= neg_d;
  end

  assign res_o = rbes_pkg::sat_mag(
      rbes_pkg::dmag_t'(prod_q >> rbes_pkg::FracW), neg_q);
endmodule

>>> rtl/rbes_div.sv
module rbes_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  rbes_pkg::dmag_t        num_i,
  input  logic [rbes_pkg::WordW-1:0] den_i,
  output logic                   busy_o,
  output logic                   done_o,
  output rbes_pkg::dmag_t        quo_o
);
  localparam int unsigned CntW = $clog2(rbes_pkg::DivW);
  logic [rbes_pkg::WordW-1:0] rem_q, rem_d;
  rbes_pkg::dmag_t num_q, quo_q;
  logic [CntW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [rbes_pkg::WordW:0] try_w;
  logic [rbes_pkg::WordW:0] diff_w;
  logic ge;

  always_comb begin
    try_w = {rem_q, num_q[rbes_pkg::DivW-1]};
    ge = try_w >= {1'b0, den_i};
    diff_w = try_w - {1'b0, den_i};
    rem_d = ge ? diff_w[rbes_pkg::WordW-1:0] : try_w[rbes_pkg::WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(rbes_pkg::DivW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_q << 1;
      quo_q <= {quo_q[rbes_pkg::DivW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

>>> rtl/rigid_body_euler_step.sv
// channel | dir | handshake                  | payload
// s_axis  | in  | s_axis_tvalid/tready       | tuser: req_type; tdata: step or load fields
// m_axis  | out | m_axis_tvalid/tready       | tdata: body state after the item
// cfg     | in  | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
// A load goes from idle straight to output. A tick takes mass/12 by reciprocal
// multiply, then nine products on the shared multiplier, each a multiply and an accumulate step, with the
// bit-serial torque/I divide (start, 56 steps, done) after the inertia product, then walls, output and idle.
// Zero inertia skips the divide; a static body skips two products.
// Reset clears the body state and loads register defaults.
// Input is taken only when idle; a result held on m_axis stalls the next finish.
`include "assert_macros.svh"
module rigid_body_euler_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tuser: req_type
  input  logic         s_axis_tuser,
  // tdata: delta_time[30:0], applied_torque, load_pos_x, load_pos_y,
  //        load_vel_x, load_vel_y, load_angle, zero pad
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_angle, out_angular_vel
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DM_GO = 4'd1,
                         S_MUL = 4'd3, S_ACC = 4'd4, S_DT_GO = 4'd5,
                         S_DT_WAIT = 4'd6, S_WALLY = 4'd7, S_WALLX = 4'd8,
                         S_OUT = 4'd9;
  localparam logic [2:0] R_MASS = 3'd0, R_W = 3'd1, R_H = 3'd2, R_AX = 3'd3,
                         R_AY = 3'd4, R_G = 3'd5, R_STAT = 3'd6;
  localparam logic REQ_LOAD = 1'b1;
  localparam rbes_pkg::word_t One = rbes_pkg::word_t'(1) <<< rbes_pkg::FracW;
  localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;

  typedef rbes_pkg::word_t word_t;

  logic [30:0] mass_q;
  logic [25:0] w_q, h_q;
  word_t ax_q, ay_q, g_q;
  logic stat_q;

  word_t px_q, py_q, vx_q, vy_q, ang_q, spin_q;
  word_t m12_q, t_q, inert_q, alpha_q, torque_q;
  logic [30:0] dt_q;
  logic [3:0] state_q;
  logic [3:0] step_q;
  logic ovalid_q;
  logic [191:0] odata_q;

  word_t mul_a, mul_b, mul_r, ay_w;
  logic div_start, div_busy, div_done;
  rbes_pkg::dmag_t div_num, div_quo;
  logic [31:0] div_den;
  logic [31:0] tq_mag;
  logic [60:0] m12_prod;
  logic out_free;

  rbes_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .res_o(mul_r));

  rbes_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  assign ay_w = rbes_pkg::sadd(ay_q, g_q);
  assign out_free = !ovalid_q || m_axis_tready;
  // mass/12 as (mass/4)/3, divide by three through the reciprocal
  assign m12_prod = 61'(mass_q[30:2]) * 61'(Recip3);
  assign tq_mag = torque_q[31] ? -torque_q : torque_q;

  always_comb begin
    mul_a = '0;
    mul_b = word_t'({1'b0, dt_q});
    case (step_q)
      4'd0: begin mul_a = word_t'({6'b0, w_q}); mul_b = word_t'({6'b0, w_q}); end
      4'd1: begin mul_a = word_t'({6'b0, h_q}); mul_b = word_t'({6'b0, h_q}); end
      4'd2: begin mul_a = m12_q; mul_b = t_q; end
      4'd3: mul_a = ax_q;
      4'd4: mul_a = ay_w;
      4'd5: mul_a = vx_q;
      4'd6: mul_a = vy_q;
      4'd7: mul_a = alpha_q;
      4'd8: mul_a = spin_q;
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    div_start = (state_q == S_DT_GO);
    div_num = rbes_pkg::dmag_t'(tq_mag) << rbes_pkg::FracW;
    div_den = inert_q;
  end

  function automatic word_t neg_sat(input word_t v);
    return (v == {1'b1, 31'b0}) ? {1'b0, {31{1'b1}}} : -v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= 31'd16777216;
      w_q <= 26'd1677722;
      h_q <= 26'd1677722;
      ax_q <= '0;
      ay_q <= '0;
      g_q <= -32'sd164584489;
      stat_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        R_MASS: mass_q <= cfg_wdata_i[30:0];
        R_W: w_q <= cfg_wdata_i[25:0];
        R_H: h_q <= cfg_wdata_i[25:0];
        R_AX: ax_q <= cfg_wdata_i;
        R_AY: ay_q <= cfg_wdata_i;
        R_G: g_q <= cfg_wdata_i;
        R_STAT: stat_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      dt_q <= s_axis_tdata[30:0];
      torque_q <= s_axis_tdata[62:31];
    end
    if (state_q == S_DM_GO) m12_q <= word_t'({4'b0, m12_prod[60:33]});
    if (state_q == S_DT_WAIT && div_done) alpha_q <= rbes_pkg::sat_mag(div_quo, torque_q[31]);
    if (state_q == S_ACC && step_q == 4'd2 && !mul_r[31] && mul_r != '0) alpha_q <= alpha_q;
    else if (state_q == S_ACC && step_q == 4'd2) alpha_q <= '0;
    if (state_q == S_ACC) begin
      case (step_q)
        4'd0: t_q <= mul_r;
        4'd1: t_q <= rbes_pkg::sadd(t_q, mul_r);
        4'd2: inert_q <= mul_r;
        default: ;
      endcase
    end
    if (state_q == S_OUT && out_free)
      odata_q <= {spin_q, ang_q, vy_q, vx_q, py_q, px_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= '0;
      ovalid_q <= 1'b0;
      px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0; ang_q <= '0; spin_q <= '0;
    end else begin
      if (state_q == S_OUT && out_free) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == REQ_LOAD) begin
              px_q <= s_axis_tdata[94:63];
              py_q <= s_axis_tdata[126:95];
              vx_q <= s_axis_tdata[158:127];
              vy_q <= s_axis_tdata[190:159];
              ang_q <= s_axis_tdata[222:191];
              spin_q <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_DM_GO;
            end
          end
        end
        S_DM_GO: begin
          step_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          step_q <= (step_q == 4'd4 && stat_q) ? 4'd7 : step_q + 1'b1;
          if (step_q == 4'd8) state_q <= S_WALLY;
          else if (step_q == 4'd2 && !mul_r[31] && mul_r != '0) state_q <= S_DT_GO;
          else state_q <= S_MUL;
          case (step_q)
            4'd3: vx_q <= rbes_pkg::sadd(vx_q, mul_r);
            4'd4: vy_q <= rbes_pkg::sadd(vy_q, mul_r);
            4'd5: px_q <= rbes_pkg::sadd(px_q, mul_r);
            4'd6: py_q <= rbes_pkg::sadd(py_q, mul_r);
            4'd7: spin_q <= rbes_pkg::sadd(spin_q, mul_r);
            4'd8: ang_q <= rbes_pkg::sadd(ang_q, mul_r);
            default: ;
          endcase
        end
        S_DT_GO: state_q <= S_DT_WAIT;
        S_DT_WAIT: if (div_done) state_q <= S_MUL;
        S_WALLY: begin
          begin : wy
            word_t lo, hi, p, v;
            lo = -One + word_t'({7'b0, h_q[25:1]});
            hi = One - word_t'({7'b0, h_q[25:1]});
            p = py_q; v = vy_q;
            if (p <= lo) begin p = lo; v = neg_sat(v); end
            if (p >= hi) begin p = hi; v = neg_sat(v); end
            py_q <= p; vy_q <= v;
          end
          state_q <= S_WALLX;
        end
        S_WALLX: begin
          begin : wx
            word_t lo, hi, p, v;
            lo = -One + word_t'({7'b0, w_q[25:1]});
            hi = One - word_t'({7'b0, w_q[25:1]});
            p = px_q; v = vx_q;
            if (p <= lo) begin p = lo; v = neg_sat(v); end
            if (p >= hi) begin p = hi; v = neg_sat(v); end
            px_q <= p; vx_q <= v;
          end
          state_q <= S_OUT;
        end
        S_OUT: if (out_free) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;

  `RBES_ASSERT(a_div_only_in_wait, clk_i, rst_ni, div_busy |-> (state_q == S_DT_WAIT), "divider busy outside wait")
  `RBES_ASSERT(a_idle_div_free, clk_i, rst_ni, s_axis_tready |-> !div_busy, "input taken while divider busy")
  `RBES_ASSERT(a_out_issued, clk_i, rst_ni, (state_q == S_OUT && out_free) |=> m_axis_tvalid, "result not presented")
endmodule
